// File: hdl/hkbt_pkg.sv
// Shared types, constants and the hash step function of the hashed key bucket table.
package hkbt_pkg;

  localparam int BUCKETS  = 1024;
  localparam int WAYS     = 4;
  localparam int BUCKET_W = $clog2(BUCKETS);
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int HASH_W   = 64;
  localparam int HANDLE_W = 32;
  localparam int LEN_W    = 32;
  localparam int USED_W   = 48;

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

  localparam logic REQ_SEARCH = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_COMMIT
  } back_state_t;

  typedef struct packed {
    logic                req;
    logic [HASH_W-1:0]   hash;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    length;
  } cmd_t;

  typedef struct packed {
    status_t             status;
    logic                found;
    logic [HANDLE_W-1:0] handle;
  } res_t;

  typedef struct packed {
    logic [HASH_W-1:0]   hash;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    length;
  } slot_t;

  typedef slot_t [WAYS-1:0] row_t;

  // The FNV prime is 2^40 + 0x1B3, so the product is a sum of shifted copies.
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-8){1'b0}}, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// File: hdl/hkbt_front.sv
// Front end: folds key bytes into the FNV-1a hash and queues finished commands.
module hkbt_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           req_type,
  input  logic [7:0]                     key_byte,
  input  logic                           key_last,
  input  logic [hkbt_pkg::HANDLE_W-1:0]  value_handle,
  input  logic [hkbt_pkg::LEN_W-1:0]     value_length,
  input  logic                           clearing,
  output logic                           cmd_valid,
  output hkbt_pkg::cmd_t                 cmd,
  input  logic                           cmd_pop
);

  logic [hkbt_pkg::HASH_W-1:0] acc;
  hkbt_pkg::cmd_t              q [2];
  hkbt_pkg::cmd_t              enq_word;
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  count;
  logic                        accept;
  logic                        enq;
  logic                        deq;

  assign full      = (count == 2'd2) || clearing;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign accept    = push && !full;
  assign enq       = accept && key_last;
  assign deq       = cmd_pop && cmd_valid;

  always_comb begin
    enq_word.req    = req_type;
    enq_word.hash   = hkbt_pkg::fnv_step(acc, key_byte);
    enq_word.handle = value_handle;
    enq_word.length = value_length;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= hkbt_pkg::FNV_BASIS;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        acc <= key_last ? hkbt_pkg::FNV_BASIS : hkbt_pkg::fnv_step(acc, key_byte);
      end
      if (enq) begin
        wr_ptr <= ~wr_ptr;
      end
      if (deq) begin
        rd_ptr <= ~rd_ptr;
      end
      if (enq && !deq) begin
        count <= count + 2'd1;
      end else if (deq && !enq) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= enq_word;
    end
  end

endmodule

// File: hdl/hkbt_back.sv
// Back end: probes the bucket memory, applies inserts and queues results.
module hkbt_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  hkbt_pkg::cmd_t                cmd,
  output logic                          cmd_pop,
  input  logic [hkbt_pkg::USED_W-1:0]   limit,
  output logic                          clearing,
  output logic                          empty,
  input  logic                          pop,
  output hkbt_pkg::res_t                res
);

  localparam int BW = hkbt_pkg::BUCKET_W;
  localparam int WW = hkbt_pkg::WAY_W;
  localparam int UW = hkbt_pkg::USED_W;

  hkbt_pkg::back_state_t state;
  hkbt_pkg::back_state_t state_next;

  hkbt_pkg::row_t mem [hkbt_pkg::BUCKETS];
  hkbt_pkg::row_t row_q;
  hkbt_pkg::row_t wr_row;
  hkbt_pkg::row_t upd_row;

  logic           mem_rd;
  logic           mem_wr;
  logic [BW-1:0]  rd_addr;
  logic [BW-1:0]  wr_addr;
  logic [BW-1:0]  clr_idx;
  logic [BW-1:0]  bucket;
  logic [BW-1:0]  probes;
  hkbt_pkg::cmd_t cur;
  logic [WW-1:0]  sel_way;
  logic [UW-1:0]  base;
  logic [UW-1:0]  used;
  logic [UW:0]    total;
  logic           over;

  logic           way_ok;
  logic           way_match;
  logic [WW-1:0]  way_idx;
  logic           last_probe;
  logic           start;

  hkbt_pkg::res_t rq [2];
  hkbt_pkg::res_t res_word;
  logic           res_push;
  logic           res_wr_ptr;
  logic           res_rd_ptr;
  logic [1:0]     res_count;
  logic           res_space;
  logic           res_deq;

  assign clearing   = (state == hkbt_pkg::S_CLEAR);
  assign res_space  = (res_count != 2'd2);
  assign empty      = (res_count == 2'd0);
  assign res        = rq[res_rd_ptr];
  assign res_deq    = pop && !empty;
  assign start      = cmd_valid && res_space;
  assign last_probe = (probes == BW'(hkbt_pkg::BUCKETS - 1));
  assign total      = {1'b0, base} + {{(UW + 1 - hkbt_pkg::LEN_W){1'b0}}, cur.length};
  assign over       = (total > {1'b0, limit});

  always_comb begin
    way_ok    = 1'b0;
    way_match = 1'b0;
    way_idx   = '0;
    for (int w = hkbt_pkg::WAYS - 1; w >= 0; w--) begin
      if ((row_q[w].hash == cur.hash) || (row_q[w].hash == '0)) begin
        way_ok    = 1'b1;
        way_match = (row_q[w].hash == cur.hash);
        way_idx   = WW'(w);
      end
    end
  end

  always_comb begin
    upd_row                 = row_q;
    upd_row[sel_way].hash   = cur.hash;
    upd_row[sel_way].handle = cur.handle;
    upd_row[sel_way].length = cur.length;
  end

  always_comb begin
    state_next = state;
    case (state)
      hkbt_pkg::S_CLEAR: begin
        if (clr_idx == BW'(hkbt_pkg::BUCKETS - 1)) begin
          state_next = hkbt_pkg::S_IDLE;
        end
      end
      hkbt_pkg::S_IDLE: begin
        if (start && (cmd.hash != '0)) begin
          state_next = hkbt_pkg::S_CHECK;
        end
      end
      hkbt_pkg::S_CHECK: begin
        if (way_ok) begin
          state_next = (cur.req == hkbt_pkg::REQ_INSERT) ? hkbt_pkg::S_COMMIT
                                                        : hkbt_pkg::S_IDLE;
        end else if (last_probe) begin
          state_next = hkbt_pkg::S_IDLE;
        end
      end
      hkbt_pkg::S_COMMIT: begin
        state_next = hkbt_pkg::S_IDLE;
      end
      default: begin
        state_next = hkbt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_rd          = 1'b0;
    mem_wr          = 1'b0;
    rd_addr         = cmd.hash[BW-1:0];
    wr_addr         = bucket;
    wr_row          = upd_row;
    cmd_pop         = 1'b0;
    res_push        = 1'b0;
    res_word.status = hkbt_pkg::ST_OK;
    res_word.found  = 1'b0;
    res_word.handle = '0;
    case (state)
      hkbt_pkg::S_CLEAR: begin
        mem_wr  = 1'b1;
        wr_addr = clr_idx;
        wr_row  = '0;
      end
      hkbt_pkg::S_IDLE: begin
        if (start) begin
          cmd_pop = 1'b1;
          if (cmd.hash == '0) begin
            res_push        = 1'b1;
            res_word.status = (cmd.req == hkbt_pkg::REQ_INSERT) ? hkbt_pkg::ST_FULL
                                                               : hkbt_pkg::ST_MISS;
          end else begin
            mem_rd = 1'b1;
          end
        end
      end
      hkbt_pkg::S_CHECK: begin
        if (way_ok) begin
          if (cur.req == hkbt_pkg::REQ_SEARCH) begin
            res_push = 1'b1;
            if (way_match) begin
              res_word.found  = 1'b1;
              res_word.handle = row_q[way_idx].handle;
            end else begin
              res_word.status = hkbt_pkg::ST_MISS;
            end
          end
        end else if (last_probe) begin
          res_push        = 1'b1;
          res_word.status = (cur.req == hkbt_pkg::REQ_INSERT) ? hkbt_pkg::ST_FULL
                                                             : hkbt_pkg::ST_MISS;
        end else begin
          mem_rd  = 1'b1;
          rd_addr = bucket + BW'(1);
        end
      end
      hkbt_pkg::S_COMMIT: begin
        res_push = 1'b1;
        if (over) begin
          res_word.status = hkbt_pkg::ST_OOM;
        end else begin
          mem_wr = 1'b1;
        end
      end
      default: begin
        mem_wr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[wr_addr] <= wr_row;
    end
    if (mem_rd) begin
      row_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= hkbt_pkg::S_CLEAR;
      clr_idx    <= '0;
      used       <= '0;
      res_wr_ptr <= 1'b0;
      res_rd_ptr <= 1'b0;
      res_count  <= 2'd0;
    end else begin
      state <= state_next;
      if (state == hkbt_pkg::S_CLEAR) begin
        clr_idx <= clr_idx + BW'(1);
      end
      if ((state == hkbt_pkg::S_COMMIT) && !over) begin
        used <= total[UW-1:0];
      end
      if (res_push) begin
        res_wr_ptr <= ~res_wr_ptr;
      end
      if (res_deq) begin
        res_rd_ptr <= ~res_rd_ptr;
      end
      if (res_push && !res_deq) begin
        res_count <= res_count + 2'd1;
      end else if (res_deq && !res_push) begin
        res_count <= res_count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      rq[res_wr_ptr] <= res_word;
    end
    if ((state == hkbt_pkg::S_IDLE) && start) begin
      cur    <= cmd;
      bucket <= cmd.hash[BW-1:0];
      probes <= '0;
    end
    if (state == hkbt_pkg::S_CHECK) begin
      if (way_ok) begin
        sel_way <= way_idx;
        base    <= way_match ? used - {{(UW - hkbt_pkg::LEN_W){1'b0}}, row_q[way_idx].length}
                             : used;
      end else begin
        bucket <= bucket + BW'(1);
        probes <= probes + BW'(1);
      end
    end
  end

endmodule

// File: hdl/hashed_key_bucket_table.sv
// Top level of the hashed key bucket table: limit register, front end and back end.
//
// Key bytes arrive on the input queue port (push/full), one byte per word, and are
// hashed with 64-bit FNV-1a at one word per cycle while full is low. The word with
// key_last set also carries req_type, value_handle and value_length and starts a
// search or an insert. Every such word gives one result word on the output queue
// port (empty/pop); other words give none. Results leave in the order the keys
// were completed. A finished key waits in a two-word command queue while the
// probe engine works. The engine reads a key's home bucket row as the key leaves
// the queue and then walks on, one bucket row per cycle, until a way holds its
// hash or is empty or every bucket was walked; an insert within the memory limit
// then writes its row. The limit is written on the cfg_valid/cfg_ready port, which
// is always ready. After reset a clearing pass empties the bucket memory; full
// stays high until it ends. When the receiver stalls, two results are held; then
// the engine stops and the command queue, then full, backs up toward the sender.
module hashed_key_bucket_table (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           req_type,
  input  logic [7:0]                     key_byte,
  input  logic                           key_last,
  input  logic [hkbt_pkg::HANDLE_W-1:0]  value_handle,
  input  logic [hkbt_pkg::LEN_W-1:0]     value_length,
  output logic                           empty,
  input  logic                           pop,
  output logic [1:0]                     status,
  output logic                           found,
  output logic [hkbt_pkg::HANDLE_W-1:0]  found_handle,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hkbt_pkg::USED_W-1:0]    cfg_data
);

  logic [hkbt_pkg::USED_W-1:0] memory_limit;
  logic                        clearing;
  logic                        cmd_valid;
  logic                        cmd_pop;
  hkbt_pkg::cmd_t              cmd;
  hkbt_pkg::res_t              res;

  assign cfg_ready    = 1'b1;
  assign status       = res.status;
  assign found        = res.found;
  assign found_handle = res.handle;

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_limit <= '1;
    end else if (cfg_valid && cfg_ready) begin
      memory_limit <= cfg_data;
    end
  end

  hkbt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .key_byte     (key_byte),
    .key_last     (key_last),
    .value_handle (value_handle),
    .value_length (value_length),
    .clearing     (clearing),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  hkbt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .limit     (memory_limit),
    .clearing  (clearing),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

endmodule

// File: verif/hashed_key_bucket_table_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the hashed key bucket table, with a scoreboard that models the table.
module hashed_key_bucket_table_tb;

  localparam int LIMIT_CYCLES  = 3000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_AT       = 30;
  localparam int HOLD_CYCLES   = 400;
  localparam int SEG_WORDS     = 325;

  typedef struct {
    logic [63:0] bytes;
    int          len;
  } key_t;

  class bucket_table_scoreboard;
    localparam logic [63:0] FNV_PRIME = 64'd1099511628211;

    logic [63:0] slot_hash   [hkbt_pkg::BUCKETS*hkbt_pkg::WAYS];
    logic [31:0] slot_handle [hkbt_pkg::BUCKETS*hkbt_pkg::WAYS];
    logic [31:0] slot_length [hkbt_pkg::BUCKETS*hkbt_pkg::WAYS];
    logic [47:0] used;
    logic [47:0] limit;
    logic [63:0] acc;
    int errors;
    hkbt_pkg::res_t pending_results [$];

    function new();
      for (int i = 0; i < hkbt_pkg::BUCKETS*hkbt_pkg::WAYS; i++) begin
        slot_hash[i]   = '0;
        slot_handle[i] = '0;
        slot_length[i] = '0;
      end
      used       = '0;
      limit      = '1;
      acc        = hkbt_pkg::FNV_BASIS;
      errors     = 0;
    endfunction

    function logic [63:0] key_hash(logic [63:0] kb, int len);
      logic [63:0] h;
      h = hkbt_pkg::FNV_BASIS;
      for (int i = 0; i < len; i++) begin
        h = (h ^ {56'd0, kb[8*i +: 8]}) * FNV_PRIME;
      end
      return h;
    endfunction

    // Walks the buckets from the home bucket and stops at a matching hash or an empty slot.
    function int locate(logic [63:0] h, output bit hit);
      int b;
      int s;
      hit = 1'b0;
      b = int'(h % hkbt_pkg::BUCKETS);
      for (int n = 0; n < hkbt_pkg::BUCKETS; n++) begin
        for (int w = 0; w < hkbt_pkg::WAYS; w++) begin
          s = b * hkbt_pkg::WAYS + w;
          if (slot_hash[s] == h) begin
            hit = 1'b1;
            return s;
          end
          if (slot_hash[s] == '0) return s;
        end
        b = (b + 1) % hkbt_pkg::BUCKETS;
      end
      return -1;
    endfunction

    function void set_limit(logic [47:0] v);
      limit = v;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void note_word(logic rq, logic [7:0] kb, logic kl, logic [31:0] vh,
                            logic [31:0] vl);
      hkbt_pkg::res_t r;
      logic [63:0] h;
      logic [63:0] base;
      logic [63:0] total;
      bit hit;
      int s;
      hit = 1'b0;
      acc = (acc ^ {56'd0, kb}) * FNV_PRIME;
      if (!kl) return;
      h = acc;
      acc = hkbt_pkg::FNV_BASIS;
      r.status = hkbt_pkg::ST_OK;
      r.found  = 1'b0;
      r.handle = '0;
      if (rq == hkbt_pkg::REQ_SEARCH) begin
        if (h != '0) s = locate(h, hit);
        else s = -1;
        if (s >= 0 && hit) begin
          r.found  = 1'b1;
          r.handle = slot_handle[s];
        end else begin
          r.status = hkbt_pkg::ST_MISS;
        end
      end else if (h == '0) begin
        r.status = hkbt_pkg::ST_FULL;
      end else begin
        s = locate(h, hit);
        if (s < 0) begin
          r.status = hkbt_pkg::ST_FULL;
        end else begin
          base  = hit ? {16'd0, used} - {32'd0, slot_length[s]} : {16'd0, used};
          total = base + {32'd0, vl};
          if (total > {16'd0, limit}) begin
            r.status = hkbt_pkg::ST_OOM;
          end else begin
            slot_hash[s]   = h;
            slot_handle[s] = vh;
            slot_length[s] = vl;
            used           = total[47:0];
          end
        end
      end
      pending_results.push_back(r);
    endfunction

    function void mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, what, exp_v, act_v);
    endfunction

    function void check_result(logic [1:0] st, logic f, logic [31:0] fh);
      hkbt_pkg::res_t e;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, status %0d found %0b handle %0h",
                 $time, st, f, fh);
        return;
      end
      e = pending_results.pop_front();
      if (e.status !== st) mismatch("status", 64'(e.status), 64'(st));
      if (e.found !== f) mismatch("found", 64'(e.found), 64'(f));
      if (e.handle !== fh) mismatch("found_handle", 64'(e.handle), 64'(fh));
    endfunction
  endclass

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        push         = 1'b0;
  logic        req_type     = 1'b0;
  logic [7:0]  key_byte     = '0;
  logic        key_last     = 1'b0;
  logic [31:0] value_handle = '0;
  logic [31:0] value_length = '0;
  logic        pop          = 1'b0;
  logic        cfg_valid    = 1'b0;
  logic [47:0] cfg_data     = '0;
  logic        full;
  logic        empty;
  logic [1:0]  status;
  logic        found;
  logic [31:0] found_handle;
  logic        cfg_ready;

  bit no_idle = 1'b0;
  int words_sent = 0;
  bucket_table_scoreboard sb;
  key_t known [$];

  hashed_key_bucket_table dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .key_byte     (key_byte),
    .key_last     (key_last),
    .value_handle (value_handle),
    .value_length (value_length),
    .empty        (empty),
    .pop          (pop),
    .status       (status),
    .found        (found),
    .found_handle (found_handle),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int idle_draw();
    if (no_idle) return 0;
    return int'($urandom_range(0, 12));
  endfunction

  function automatic int home_bucket(logic [63:0] kb, int len);
    return int'(sb.key_hash(kb, len) % hkbt_pkg::BUCKETS);
  endfunction

  function automatic key_t key_of(logic [63:0] kb, int len);
    key_t k;
    k.bytes = kb;
    k.len   = len;
    return k;
  endfunction

  task automatic put_word(input logic rq, input logic [7:0] kb, input logic kl,
                          input logic [31:0] vh, input logic [31:0] vl);
    int gap;
    gap = idle_draw();
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push         <= 1'b1;
    req_type     <= rq;
    key_byte     <= kb;
    key_last     <= kl;
    value_handle <= vh;
    value_length <= vl;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_word(rq, kb, kl, vh, vl);
    words_sent++;
  endtask

  // Only the last word of a key carries a meaningful request; the others get noise.
  task automatic send_key(input key_t k, input logic rq, input logic [31:0] vh,
                          input logic [31:0] vl);
    for (int i = 0; i < k.len; i++) begin
      if (i == k.len - 1) put_word(rq, k.bytes[8*i +: 8], 1'b1, vh, vl);
      else put_word(1'($urandom), k.bytes[8*i +: 8], 1'b0, $urandom, $urandom);
    end
  endtask

  task automatic set_memory_limit(input logic [47:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_limit(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_key_op();
    key_t k;
    logic rq;
    logic [31:0] vh;
    logic [31:0] vl;
    int r;
    int target;
    r = int'($urandom_range(0, 99));
    if (known.size() > 0 && r < 45) begin
      k = known[$urandom_range(0, known.size() - 1)];
    end else if (r < 65) begin
      // Keys crowded into a few buckets spill into their neighbors, and past the top one wraps.
      case ($urandom_range(0, 2))
        0: target = hkbt_pkg::BUCKETS - 1;
        1: target = hkbt_pkg::BUCKETS - 2;
        default: target = 7;
      endcase
      k.len = 3;
      do begin
        k.bytes = {40'd0, 24'($urandom)};
      end while (home_bucket(k.bytes, 3) != target);
    end else begin
      if ($urandom_range(0, 3) == 0) k.len = int'($urandom_range(4, 8));
      else k.len = int'($urandom_range(1, 3));
      k.bytes = {$urandom, $urandom};
    end
    rq = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: vh = '0;
      1: vh = '1;
      default: vh = $urandom;
    endcase
    case ($urandom_range(0, 7))
      0: vl = '0;
      1: vl = '1;
      2, 3: vl = $urandom;
      default: vl = $urandom_range(0, 4095);
    endcase
    send_key(k, rq, vh, vl);
    if (rq == hkbt_pkg::REQ_INSERT) known.push_back(k);
  endtask

  initial begin : result_side
    int gap;
    int taken;
    taken = 0;
    wait (rst == 1'b0);
    forever begin
      gap = idle_draw();
      @(negedge clk);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      sb.check_result(status, found, found_handle);
      taken++;
      if (taken == HOLD_AT) begin
        @(negedge clk);
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("hashed_key_bucket_table_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    key_t kz;
    key_t kf;
    logic [47:0] lim;
    int seg;
    int start;
    sb = new();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_memory_limit('1);
    kz = key_of(64'h00, 1);
    kf = key_of(64'hFFFF, 2);
    send_key(kz, hkbt_pkg::REQ_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_key(kf, hkbt_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_key(kz, hkbt_pkg::REQ_SEARCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_key(kf, hkbt_pkg::REQ_SEARCH, 32'h0000_0000, 32'h0000_0000);
    send_key(key_of(64'h03_0201, 3), hkbt_pkg::REQ_SEARCH, 32'h0, 32'h0);
    send_key(kz, hkbt_pkg::REQ_INSERT, 32'h1234_5678, 32'd10);
    send_key(kz, hkbt_pkg::REQ_SEARCH, 32'h0, 32'h0);
    // This eight-byte key is published as one that folds to a zero hash.
    send_key(key_of(64'h3608_8742_53B9_6BD5, 8), hkbt_pkg::REQ_INSERT, 32'h5555_AAAA, 32'd1);
    send_key(key_of(64'h3608_8742_53B9_6BD5, 8), hkbt_pkg::REQ_SEARCH, 32'h0, 32'h0);
    known.push_back(kz);
    known.push_back(kf);

    settle();
    set_memory_limit(sb.used);
    send_key(key_of(64'h11, 1), hkbt_pkg::REQ_INSERT, 32'hA5A5_5A5A, 32'd0);
    send_key(kz, hkbt_pkg::REQ_INSERT, 32'h0BAD_F00D, 32'd11);
    send_key(kz, hkbt_pkg::REQ_SEARCH, 32'h0, 32'h0);

    settle();
    set_memory_limit('0);
    send_key(key_of(64'h22, 1), hkbt_pkg::REQ_INSERT, 32'h0000_0001, 32'd0);
    send_key(kf, hkbt_pkg::REQ_INSERT, 32'h0000_0002, 32'd0);

    for (seg = 0; seg < 4; seg++) begin
      settle();
      case (seg)
        0: lim = '1;
        1: lim = sb.used + 48'($urandom_range(0, 200000));
        2: lim = 48'({$urandom, $urandom});
        default: lim = sb.used >> 1;
      endcase
      set_memory_limit(lim);
      no_idle = (seg == 2);
      start = words_sent;
      while (words_sent - start < SEG_WORDS) random_key_op();
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("hashed_key_bucket_table_tb OK");
    end else begin
      $display("hashed_key_bucket_table_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/hkbt_pkg.sv
hdl/hkbt_front.sv
hdl/hkbt_back.sv
hdl/hashed_key_bucket_table.sv
verif/hashed_key_bucket_table_tb.sv
